### rtl/core/lpwbs_pkg.sv
// ----------------------------------------------------------------------------
// lpwbs_pkg
// Shared types, constants and helper functions for the pulse-width LED bit
// sender.
// ----------------------------------------------------------------------------
package lpwbs_pkg;

  localparam int unsigned TimerWidth  = 16;
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned BitCntWidth = $clog2(ByteWidth + 1);
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QPtrWidth   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntWidth   = $clog2(QueueDepth + 1);

  localparam logic [BitCntWidth-1:0] BitsPerByte = BitCntWidth'(ByteWidth);
  localparam logic [63:0]            TimerMax    = (64'd1 << TimerWidth) - 64'd1;

  localparam logic [CfgWidth-1:0] BitPeriodRst  = CfgWidth'(50);
  localparam logic [CfgWidth-1:0] OneHighRst    = CfgWidth'(32);
  localparam logic [CfgWidth-1:0] ZeroHighRst   = CfgWidth'(16);
  localparam logic [CfgWidth-1:0] ResetTicksRst = CfgWidth'(2500);
  localparam logic [CfgWidth-1:0] MinPeriod     = CfgWidth'(2);

  typedef enum logic [1:0] {
    PhIdle,
    PhHigh,
    PhLow,
    PhReset
  } phase_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgBitPeriod,
    CfgOneHigh,
    CfgZeroHigh,
    CfgResetTicks
  } cfg_idx_e;

  typedef struct packed {
    logic                 op;
    logic [ByteWidth-1:0] data_byte;
    logic                 last_byte;
  } in_item_t;

  typedef struct packed {
    logic pin_level;
    logic byte_taken;
    logic busy_res;
    logic frame_done;
  } out_item_t;

  typedef struct packed {
    logic                 offer;
    logic [ByteWidth-1:0] data;
    logic                 last;
  } work_t;

  typedef struct packed {
    logic [CfgWidth-1:0] bit_period;
    logic [CfgWidth-1:0] one_high;
    logic [CfgWidth-1:0] zero_high;
    logic [CfgWidth-1:0] reset_ticks;
  } cfg_t;

  function automatic logic [TimerWidth-1:0] timer_cap(logic [CfgWidth-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    if (w > TimerMax) begin
      return TimerWidth'(TimerMax);
    end
    return TimerWidth'(w);
  endfunction

  function automatic logic [CfgWidth-1:0] eff_period(cfg_t cfg);
    return (cfg.bit_period < MinPeriod) ? MinPeriod : cfg.bit_period;
  endfunction

  function automatic logic [CfgWidth-1:0] eff_high(cfg_t cfg, logic one);
    logic [CfgWidth-1:0] p;
    logic [CfgWidth-1:0] h;
    p = eff_period(cfg);
    h = one ? cfg.one_high : cfg.zero_high;
    if (h == '0) begin
      h = CfgWidth'(1);
    end
    if (h >= p) begin
      h = p - CfgWidth'(1);
    end
    return h;
  endfunction

endpackage

### rtl/core/lpwbs_front.sv
// ----------------------------------------------------------------------------
// lpwbs_front
// Input side: takes requests into a short queue and classifies each one as a
// plain tick or a byte offer for the encoder engine.
// ----------------------------------------------------------------------------
module lpwbs_front
  import lpwbs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t in_data_i,
  output logic     work_valid_o,
  input  logic     work_ready_i,
  output work_t    work_o
);

  work_t                mem_q [QueueDepth];
  logic [QPtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntWidth-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;
  work_t                cls;

  assign full         = (cnt_q == QCntWidth'(QueueDepth));
  assign work_valid_o = (cnt_q != '0);
  assign do_push      = push && !full;
  assign do_pop       = work_valid_o && work_ready_i;

  always_comb begin
    cls.offer = in_data_i.op;
    cls.data  = in_data_i.data_byte;
    cls.last  = in_data_i.op && in_data_i.last_byte;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrWidth'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrWidth'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntWidth'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  assign work_o = mem_q[rd_ptr_q];

endmodule

### rtl/core/lpwbs_engine.sv
// ----------------------------------------------------------------------------
// lpwbs_engine
// Back side: advances the bit timing state machine by one tick per request
// and produces the line level and status for that tick.
// ----------------------------------------------------------------------------
module lpwbs_engine
  import lpwbs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      work_valid_i,
  output logic      work_ready_o,
  input  work_t     work_i,
  input  logic      res_full_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  phase_e                  phase_q, phase_d, cur_phase;
  logic [ByteWidth-1:0]    shift_q, shift_d, cur_shift;
  logic [BitCntWidth-1:0]  bits_q, bits_d, cur_bits, bits_m;
  logic [TimerWidth-1:0]   count_q, count_d, cur_count, dec;
  logic                    fend_q, fend_d, cur_fend;
  logic                    take, step_en;

  assign work_ready_o = !res_full_i;
  assign step_en      = work_valid_i && work_ready_o;
  assign res_valid_o  = step_en;

  always_comb begin
    take      = work_i.offer && (phase_q == PhIdle);
    cur_phase = take ? PhHigh : phase_q;
    cur_shift = take ? work_i.data : shift_q;
    cur_bits  = take ? BitsPerByte : bits_q;
    cur_fend  = take ? work_i.last : fend_q;
    cur_count = take ? timer_cap(eff_high(cfg_i, work_i.data[ByteWidth-1])) : count_q;
    dec       = (cur_count != '0) ? cur_count - TimerWidth'(1) : '0;
  end

  always_comb begin
    phase_d = cur_phase;
    shift_d = cur_shift;
    bits_d  = cur_bits;
    count_d = cur_count;
    fend_d  = cur_fend;
    bits_m  = (cur_bits != '0) ? cur_bits - BitCntWidth'(1) : '0;
    unique case (cur_phase)
      PhHigh: begin
        count_d = dec;
        if (dec == '0) begin
          phase_d = PhLow;
          count_d = timer_cap(eff_period(cfg_i) - eff_high(cfg_i, cur_shift[ByteWidth-1]));
        end
      end
      PhLow: begin
        count_d = dec;
        if (dec == '0) begin
          shift_d = cur_shift << 1;
          bits_d  = bits_m;
          if (bits_m != '0) begin
            phase_d = PhHigh;
            count_d = timer_cap(eff_high(cfg_i, cur_shift[ByteWidth-2]));
          end else if (cur_fend) begin
            phase_d = PhReset;
            count_d = timer_cap((cfg_i.reset_ticks == '0) ? CfgWidth'(1) : cfg_i.reset_ticks);
          end else begin
            phase_d = PhIdle;
          end
        end
      end
      PhReset: begin
        count_d = dec;
        if (dec == '0) begin
          phase_d = PhIdle;
          fend_d  = 1'b0;
        end
      end
      PhIdle: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.pin_level  = (cur_phase == PhHigh);
    res_o.byte_taken = take;
    res_o.busy_res   = (cur_phase != PhIdle);
    res_o.frame_done = (cur_phase == PhReset) && (dec == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      shift_q <= '0;
      bits_q  <= '0;
      count_q <= '0;
      fend_q  <= 1'b0;
    end else if (step_en) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      count_q <= count_d;
      fend_q  <= fend_d;
    end
  end

endmodule

### rtl/core/lpwbs_outq.sv
// ----------------------------------------------------------------------------
// lpwbs_outq
// Result queue: holds finished tick results until the consumer pops them.
// ----------------------------------------------------------------------------
module lpwbs_outq
  import lpwbs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      res_valid_i,
  input  out_item_t res_i,
  output logic      res_full_o,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data_o
);

  out_item_t            mem_q [QueueDepth];
  logic [QPtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntWidth-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign res_full_o = (cnt_q == QCntWidth'(QueueDepth));
  assign empty      = (cnt_q == '0);
  assign do_push    = res_valid_i && !res_full_o;
  assign do_pop     = pop && !empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrWidth'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrWidth'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntWidth'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  assign out_data_o = mem_q[rd_ptr_q];

endmodule

### rtl/core/led_pulse_width_bit_sender.sv
// Timing: an accepted request is registered in the input queue and its result
// in the result queue, where it can be popped. Throughput: one request per
// cycle while the result queue has room, set by the engine's single-tick step.
// Two-entry queues on both sides let input and output stall independently.
// Reset clears both queues and the encoder state; registers return to defaults.
// ----------------------------------------------------------------------------
// led_pulse_width_bit_sender
// Pulse-width line encoder for chained RGB LEDs, one request per timer tick.
// ----------------------------------------------------------------------------
module led_pulse_width_bit_sender
  import lpwbs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  in_item_t               in_data_i,
  output logic                   empty,
  input  logic                   pop,
  output out_item_t              out_data_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i
);

  cfg_t      cfg_q;
  logic      work_valid, work_ready;
  work_t     work;
  logic      res_valid, res_full;
  out_item_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_period  <= BitPeriodRst;
      cfg_q.one_high    <= OneHighRst;
      cfg_q.zero_high   <= ZeroHighRst;
      cfg_q.reset_ticks <= ResetTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgBitPeriod:  cfg_q.bit_period  <= cfg_data_i;
        CfgOneHigh:    cfg_q.one_high    <= cfg_data_i;
        CfgZeroHigh:   cfg_q.zero_high   <= cfg_data_i;
        CfgResetTicks: cfg_q.reset_ticks <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  lpwbs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_data_i    (in_data_i),
    .work_valid_o (work_valid),
    .work_ready_i (work_ready),
    .work_o       (work)
  );

  lpwbs_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .work_valid_i (work_valid),
    .work_ready_o (work_ready),
    .work_i       (work),
    .res_full_i   (res_full),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  lpwbs_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_full_o  (res_full),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/core/lpwbs_checker.sv
// ----------------------------------------------------------------------------
// lpwbs_checker
// Port-level checks on the result stream of the LED bit sender.
// ----------------------------------------------------------------------------
module lpwbs_checker
  import lpwbs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_item_t out_data_o
);

  a_held_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("Result withdrawn before it was popped.");

  a_held_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(out_data_o))
    else $error("Stalled result changed.");

  a_taken_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_data_o.byte_taken |-> out_data_o.pin_level && out_data_o.busy_res)
    else $error("Accepted byte did not start a high phase.");

  a_done_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_data_o.frame_done |-> out_data_o.busy_res && !out_data_o.pin_level)
    else $error("Frame end reported outside a low latch phase.");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_data_o.busy_res |-> !out_data_o.pin_level && !out_data_o.frame_done)
    else $error("Line activity reported while idle.");

endmodule

bind led_pulse_width_bit_sender lpwbs_checker u_lpwbs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o)
);
